### design/tqvg_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers of the tile quad vertex generator.
package tqvg_pkg;

    // field widths
    localparam int COL_W      = 8;
    localparam int ROW_W      = 8;
    localparam int TILE_W     = 16;
    localparam int MAPCOL_W   = 9;
    localparam int TSIZE_W    = 9;
    localparam int GAP_W      = 8;
    localparam int ATLAS_W    = 15;
    localparam int SLOT_W     = 19;
    localparam int CORNER_W   = 3;
    localparam int SCREEN_W   = 17;
    localparam int TEXX_W     = 22;
    localparam int TEXY_W     = 26;

    // ports
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 104;

    // register reset values
    localparam logic [MAPCOL_W-1:0] MAP_COLUMNS_RST = 9'd1;
    localparam logic [TSIZE_W-1:0]  TILE_WIDTH_RST  = 9'd16;
    localparam logic [TSIZE_W-1:0]  TILE_HEIGHT_RST = 9'd16;
    localparam logic [GAP_W-1:0]    TILE_GAP_RST    = 8'd0;
    localparam logic [ATLAS_W-1:0]  ATLAS_WIDTH_RST = 15'd256;
    // tiles per row that the reset values give
    localparam logic [ATLAS_W-1:0]  PER_ROW_RST     = ATLAS_WIDTH_RST / 15'(TILE_WIDTH_RST);

    // atlas entry divider pipeline
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = TILE_W / DIV_STAGES;

    localparam int VERTS_PER_TILE = 6;
    localparam logic [CORNER_W-1:0] CORNER_LAST = CORNER_W'(VERTS_PER_TILE - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_COLUMNS = 3'd0,
        REG_TILE_WIDTH  = 3'd1,
        REG_TILE_HEIGHT = 3'd2,
        REG_TILE_GAP    = 3'd3,
        REG_ATLAS_WIDTH = 3'd4
    } t_cfg_reg;

    // tiles-per-row divider
    typedef enum logic [1:0] {
        PR_IDLE,
        PR_LOAD,
        PR_STEP
    } t_pr_state;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cell;

    // per-tile start values handed to the vertex sequencer
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [SCREEN_W-1:0] sx0;
        logic [SCREEN_W-1:0] sy0;
        logic [TEXX_W-1:0]   tx0;
        logic [TEXY_W-1:0]   ty0;
    } t_tile_base;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [CORNER_W-1:0] corner;
        logic [SCREEN_W-1:0] sx;
        logic [SCREEN_W-1:0] sy;
        logic [TEXX_W-1:0]   tx;
        logic [TEXY_W-1:0]   ty;
        logic                last;
    } t_vertex;

    // remainder / shifting dividend-quotient pair of the entry divider
    typedef struct packed {
        logic [ATLAS_W-1:0] rem;
        logic [TILE_W-1:0]  dq;
    } t_div_state;

    // one restoring division step
    function automatic t_div_state div_step(input t_div_state st,
                                            input logic [ATLAS_W-1:0] d);
        logic [ATLAS_W:0] trial;
        logic [ATLAS_W:0] diff;
        logic             ge;
        t_div_state       res;
        trial   = {st.rem, st.dq[TILE_W-1]};
        diff    = trial - {1'b0, d};
        ge      = (trial >= {1'b0, d});
        res.rem = ge ? diff[ATLAS_W-1:0] : trial[ATLAS_W-1:0];
        res.dq  = {st.dq[TILE_W-2:0], ge};
        return res;
    endfunction

    // corners 1, 4 and 5 sit on the right edge, 2, 3 and 5 on the bottom edge
    function automatic logic corner_right(input logic [CORNER_W-1:0] c);
        return (c == 3'd1) || (c == 3'd4) || (c == 3'd5);
    endfunction

    function automatic logic corner_bottom(input logic [CORNER_W-1:0] c);
        return (c == 3'd2) || (c == 3'd3) || (c == 3'd5);
    endfunction

endpackage

### design/tqvg_quot_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: atlas entry split into atlas row and column.
module tqvg_quot_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tqvg_pkg::ATLAS_W-1:0]   i_divisor,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tqvg_pkg::TILE_W-1:0]    i_entry,
    input  tqvg_pkg::t_cell                i_cell,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tqvg_pkg::TILE_W-1:0]    o_quo,
    output logic [tqvg_pkg::ATLAS_W-1:0]   o_rem,
    output tqvg_pkg::t_cell                o_cell
);

    localparam int NS = tqvg_pkg::DIV_STAGES;

    logic [NS-1:0]          r_valid;
    tqvg_pkg::t_div_state   r_div  [NS];
    tqvg_pkg::t_cell        r_cell [NS];

    tqvg_pkg::t_div_state   n_div    [NS];
    tqvg_pkg::t_div_state   stg_in   [NS];
    tqvg_pkg::t_cell        stg_cell [NS];
    logic [NS-1:0]          stg_in_valid;
    logic [NS:0]            stg_rdy;

    always_comb begin
        stg_in[0].rem   = '0;
        stg_in[0].dq    = i_entry;
        stg_cell[0]     = i_cell;
        stg_in_valid[0] = i_valid;
        for (int s = 1; s < NS; s++) begin
            stg_in[s]       = r_div[s-1];
            stg_cell[s]     = r_cell[s-1];
            stg_in_valid[s] = r_valid[s-1];
        end
    end

    // a fixed group of steps per stage
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            n_div[s] = stg_in[s];
            for (int k = 0; k < tqvg_pkg::DIV_STEPS; k++) begin
                n_div[s] = tqvg_pkg::div_step(n_div[s], i_divisor);
            end
        end
    end

    always_comb begin
        stg_rdy[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            stg_rdy[s] = !r_valid[s] || stg_rdy[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (stg_rdy[s]) begin
                    r_valid[s] <= stg_in_valid[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS; s++) begin
            if (stg_rdy[s] && stg_in_valid[s]) begin
                r_div[s]  <= n_div[s];
                r_cell[s] <= stg_cell[s];
            end
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_valid[NS-1];
    assign o_quo   = r_div[NS-1].dq;
    assign o_rem   = r_div[NS-1].rem;
    assign o_cell  = r_cell[NS-1];

endmodule

### design/tqvg_vertex_seq.sv
`timescale 1ns / 1ps
// Vertex sequencer: expands one tile into six registered vertex transfers.
module tqvg_vertex_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tqvg_pkg::TSIZE_W-1:0]   i_tile_w,
    input  logic [tqvg_pkg::TSIZE_W-1:0]   i_tile_h,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  tqvg_pkg::t_tile_base           i_base,
    output logic                           o_valid,
    input  logic                           i_ready,
    output tqvg_pkg::t_vertex              o_vertex
);

    logic                               r_busy;
    logic [tqvg_pkg::CORNER_W-1:0]      r_corner;
    tqvg_pkg::t_tile_base               r_base;
    logic                               r_m_valid;
    tqvg_pkg::t_vertex                  r_m;

    tqvg_pkg::t_vertex                  n_vtx;
    logic                               out_load;
    logic                               emit;
    logic                               take;
    logic [tqvg_pkg::SCREEN_W-1:0]      dx_s;
    logic [tqvg_pkg::SCREEN_W-1:0]      dy_s;
    logic [tqvg_pkg::TEXX_W-1:0]        dx_t;
    logic [tqvg_pkg::TEXY_W-1:0]        dy_t;

    assign out_load = !r_m_valid || i_ready;
    assign emit     = r_busy && out_load;
    assign o_ready  = !r_busy || (emit && (r_corner == tqvg_pkg::CORNER_LAST));
    assign take     = i_valid && o_ready;

    always_comb begin
        dx_s = tqvg_pkg::corner_right(r_corner)
             ? {{(tqvg_pkg::SCREEN_W - tqvg_pkg::TSIZE_W){1'b0}}, i_tile_w} : '0;
        dy_s = tqvg_pkg::corner_bottom(r_corner)
             ? {{(tqvg_pkg::SCREEN_W - tqvg_pkg::TSIZE_W){1'b0}}, i_tile_h} : '0;
        dx_t = tqvg_pkg::corner_right(r_corner)
             ? {{(tqvg_pkg::TEXX_W - tqvg_pkg::TSIZE_W){1'b0}}, i_tile_w} : '0;
        dy_t = tqvg_pkg::corner_bottom(r_corner)
             ? {{(tqvg_pkg::TEXY_W - tqvg_pkg::TSIZE_W){1'b0}}, i_tile_h} : '0;

        n_vtx.slot   = r_base.slot
                     + {{(tqvg_pkg::SLOT_W - tqvg_pkg::CORNER_W){1'b0}}, r_corner};
        n_vtx.corner = r_corner;
        n_vtx.sx     = r_base.sx0 + dx_s;
        n_vtx.sy     = r_base.sy0 + dy_s;
        n_vtx.tx     = r_base.tx0 + dx_t;
        n_vtx.ty     = r_base.ty0 + dy_t;
        n_vtx.last   = (r_corner == tqvg_pkg::CORNER_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_corner  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy   <= 1'b1;
                r_corner <= '0;
            end else if (emit) begin
                if (r_corner == tqvg_pkg::CORNER_LAST) begin
                    r_busy <= 1'b0;
                end
                r_corner <= r_corner + 1'b1;
            end
            if (out_load) begin
                r_m_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_base <= i_base;
        end
        if (emit) begin
            r_m <= n_vtx;
        end
    end

    assign o_valid  = r_m_valid;
    assign o_vertex = r_m;

    a_corner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_corner <= tqvg_pkg::CORNER_LAST))
        else $error("corner counter past last corner");

    a_tile_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && i_ready && !r_m.last) |=> r_m_valid)
        else $error("vertex missing inside a tile");

    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && i_ready && !r_m.last) |=> (r_m.slot == ($past(r_m.slot) + 1'b1)))
        else $error("vertex slot not consecutive inside a tile");

endmodule

### design/tile_quad_vertex_generator_unit.sv
`timescale 1ns / 1ps
// Top level of the tile quad vertex generator.
//
// Each accepted map cell with a nonzero tile number yields six vertex transfers (two triangles)
// on the master stream, one per cycle when the sink keeps up; a cell with tile number 0 is
// accepted and produces nothing, and such cells can be taken one per cycle while tready is high.
// Cells enter an eight-register pipeline (four stages of a restoring divider that splits the
// atlas entry into atlas row and column, one multiply stage, one slot stage, then the tile
// register of the vertex sequencer and its output register that drives the master stream).
// The tiles-per-row figure is kept in a register and rebuilt by a one-bit-per-cycle divider
// after every write to tile_width or atlas_width: the slave stream holds tready low after such
// a write until the rebuild is done. Other register writes take effect at once. There is no
// clearing pass after reset; the configuration port is always ready.
module tile_quad_vertex_generator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tqvg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tqvg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // map cells
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tqvg_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // cell_column, cell_row, tile_number
    // vertices
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // vertex_slot, corner, screen_x, screen_y, texel_x, texel_y
    output logic [tqvg_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast
);

    // ---------------- configuration registers ----------------
    logic [tqvg_pkg::MAPCOL_W-1:0]  r_map_columns;
    logic [tqvg_pkg::TSIZE_W-1:0]   r_tile_width;
    logic [tqvg_pkg::TSIZE_W-1:0]   r_tile_height;
    logic [tqvg_pkg::GAP_W-1:0]     r_tile_gap;
    logic [tqvg_pkg::ATLAS_W-1:0]   r_atlas_width;
    logic                           cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_columns <= tqvg_pkg::MAP_COLUMNS_RST;
            r_tile_width  <= tqvg_pkg::TILE_WIDTH_RST;
            r_tile_height <= tqvg_pkg::TILE_HEIGHT_RST;
            r_tile_gap    <= tqvg_pkg::TILE_GAP_RST;
            r_atlas_width <= tqvg_pkg::ATLAS_WIDTH_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                tqvg_pkg::REG_MAP_COLUMNS: r_map_columns <= i_cfg_data[tqvg_pkg::MAPCOL_W-1:0];
                tqvg_pkg::REG_TILE_WIDTH:  r_tile_width  <= i_cfg_data[tqvg_pkg::TSIZE_W-1:0];
                tqvg_pkg::REG_TILE_HEIGHT: r_tile_height <= i_cfg_data[tqvg_pkg::TSIZE_W-1:0];
                tqvg_pkg::REG_TILE_GAP:    r_tile_gap    <= i_cfg_data[tqvg_pkg::GAP_W-1:0];
                tqvg_pkg::REG_ATLAS_WIDTH: r_atlas_width <= i_cfg_data[tqvg_pkg::ATLAS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- tiles per row: atlas_width / tile_width ----------------
    localparam logic [3:0] PR_STEPS_LAST = 4'(tqvg_pkg::ATLAS_W - 1);

    tqvg_pkg::t_pr_state            r_pr_state;
    tqvg_pkg::t_pr_state            n_pr_state;
    logic [3:0]                     r_pr_cnt;
    logic [tqvg_pkg::TSIZE_W-1:0]   r_pr_rem;
    logic [tqvg_pkg::ATLAS_W-1:0]   r_pr_dq;
    logic [tqvg_pkg::ATLAS_W-1:0]   r_per_row;

    logic                           pr_busy;
    logic                           pr_load;
    logic                           pr_step;
    logic                           cfg_hits_div;
    logic [tqvg_pkg::TSIZE_W-1:0]   pr_div;
    logic [tqvg_pkg::TSIZE_W:0]     pr_trial;
    logic [tqvg_pkg::TSIZE_W:0]     pr_diff;
    logic                           pr_ge;
    logic [tqvg_pkg::TSIZE_W-1:0]   n_pr_rem;
    logic [tqvg_pkg::ATLAS_W-1:0]   n_pr_dq;

    assign cfg_hits_div = cfg_wr && ((i_cfg_index == tqvg_pkg::REG_TILE_WIDTH) ||
                                     (i_cfg_index == tqvg_pkg::REG_ATLAS_WIDTH));

    always_comb begin
        n_pr_state = r_pr_state;
        if (cfg_hits_div) begin
            n_pr_state = tqvg_pkg::PR_LOAD;
        end else begin
            unique case (r_pr_state)
                tqvg_pkg::PR_IDLE: n_pr_state = tqvg_pkg::PR_IDLE;
                tqvg_pkg::PR_LOAD: n_pr_state = tqvg_pkg::PR_STEP;
                tqvg_pkg::PR_STEP: begin
                    if (r_pr_cnt == PR_STEPS_LAST) begin
                        n_pr_state = tqvg_pkg::PR_IDLE;
                    end
                end
                default: n_pr_state = tqvg_pkg::PR_IDLE;
            endcase
        end
    end

    always_comb begin
        pr_busy = 1'b0;
        pr_load = 1'b0;
        pr_step = 1'b0;
        unique case (r_pr_state)
            tqvg_pkg::PR_IDLE: ;
            tqvg_pkg::PR_LOAD: begin
                pr_busy = 1'b1;
                pr_load = 1'b1;
            end
            tqvg_pkg::PR_STEP: begin
                pr_busy = 1'b1;
                pr_step = 1'b1;
            end
            default: pr_busy = 1'b1;
        endcase
    end

    // zero tile width divides as one
    always_comb begin
        pr_div   = (r_tile_width == '0) ? tqvg_pkg::TSIZE_W'(1) : r_tile_width;
        pr_trial = {r_pr_rem, r_pr_dq[tqvg_pkg::ATLAS_W-1]};
        pr_diff  = pr_trial - {1'b0, pr_div};
        pr_ge    = (pr_trial >= {1'b0, pr_div});
        n_pr_rem = pr_ge ? pr_diff[tqvg_pkg::TSIZE_W-1:0] : pr_trial[tqvg_pkg::TSIZE_W-1:0];
        n_pr_dq  = {r_pr_dq[tqvg_pkg::ATLAS_W-2:0], pr_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_state <= tqvg_pkg::PR_IDLE;
            r_pr_cnt   <= '0;
            r_per_row  <= tqvg_pkg::PER_ROW_RST;
        end else begin
            r_pr_state <= n_pr_state;
            if (pr_load) begin
                r_pr_cnt <= '0;
            end else if (pr_step) begin
                r_pr_cnt <= r_pr_cnt + 1'b1;
                if (r_pr_cnt == PR_STEPS_LAST) begin
                    // at least one tile per row
                    r_per_row <= (n_pr_dq == '0) ? tqvg_pkg::ATLAS_W'(1) : n_pr_dq;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pr_load) begin
            r_pr_rem <= '0;
            r_pr_dq  <= r_atlas_width;
        end else if (pr_step) begin
            r_pr_rem <= n_pr_rem;
            r_pr_dq  <= n_pr_dq;
        end
    end

    // ---------------- input and atlas entry division ----------------
    tqvg_pkg::t_cell                in_cell;
    logic [tqvg_pkg::TILE_W-1:0]    in_tile;
    logic [tqvg_pkg::TILE_W-1:0]    in_entry;
    logic                           qp_in_valid;
    logic                           qp_in_ready;
    logic                           qp_out_valid;
    logic [tqvg_pkg::TILE_W-1:0]    qp_quo;
    logic [tqvg_pkg::ATLAS_W-1:0]   qp_rem;
    tqvg_pkg::t_cell                qp_cell;
    logic                           s5_ready;
    logic                           s6_ready;
    logic                           seq_in_ready;

    assign in_cell.col = s_axis_tdata[tqvg_pkg::COL_W-1:0];
    assign in_cell.row = s_axis_tdata[tqvg_pkg::COL_W +: tqvg_pkg::ROW_W];
    assign in_tile     = s_axis_tdata[tqvg_pkg::COL_W + tqvg_pkg::ROW_W +: tqvg_pkg::TILE_W];
    assign in_entry    = in_tile - 1'b1;

    // empty cells are taken and dropped here
    assign qp_in_valid   = s_axis_tvalid && !pr_busy && (in_tile != '0);
    assign s_axis_tready = !pr_busy && qp_in_ready;

    tqvg_quot_pipe u_quot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_divisor (r_per_row),
        .i_valid   (qp_in_valid),
        .o_ready   (qp_in_ready),
        .i_entry   (in_entry),
        .i_cell    (in_cell),
        .o_valid   (qp_out_valid),
        .i_ready   (s5_ready),
        .o_quo     (qp_quo),
        .o_rem     (qp_rem),
        .o_cell    (qp_cell)
    );

    // ---------------- multiply stage ----------------
    logic                            r_s5_valid;
    logic [tqvg_pkg::COL_W-1:0]      r_s5_col;
    logic [tqvg_pkg::SCREEN_W-1:0]   r_s5_rowmc;
    logic [tqvg_pkg::SCREEN_W-1:0]   r_s5_sx0;
    logic [tqvg_pkg::SCREEN_W-1:0]   r_s5_sy0;
    logic [tqvg_pkg::TEXX_W-1:0]     r_s5_tx0;
    logic [tqvg_pkg::TEXY_W-1:0]     r_s5_ty0;
    logic [tqvg_pkg::TSIZE_W:0]      w_pitch;
    logic [tqvg_pkg::TSIZE_W:0]      h_pitch;

    assign w_pitch  = {1'b0, r_tile_width}  + {2'b0, r_tile_gap};
    assign h_pitch  = {1'b0, r_tile_height} + {2'b0, r_tile_gap};
    assign s5_ready = !r_s5_valid || s6_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (s5_ready) begin
            r_s5_valid <= qp_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_ready && qp_out_valid) begin
            r_s5_col   <= qp_cell.col;
            r_s5_rowmc <= {9'd0, qp_cell.row} * {8'd0, r_map_columns};
            r_s5_sx0   <= {9'd0, qp_cell.col} * {8'd0, r_tile_width};
            r_s5_sy0   <= {9'd0, qp_cell.row} * {8'd0, r_tile_height};
            r_s5_tx0   <= {7'd0, qp_rem} * {12'd0, w_pitch};
            r_s5_ty0   <= {10'd0, qp_quo} * {16'd0, h_pitch};
        end
    end

    // ---------------- vertex slot stage ----------------
    logic                   r_s6_valid;
    tqvg_pkg::t_tile_base   r_s6_base;
    logic [17:0]            cell_idx;
    logic [19:0]            idx_x4;
    logic [19:0]            idx_x2;

    assign cell_idx = {1'b0, r_s5_rowmc} + {10'd0, r_s5_col};
    assign idx_x4   = {cell_idx, 2'b00};
    assign idx_x2   = {1'b0, cell_idx, 1'b0};
    assign s6_ready = !r_s6_valid || seq_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (s6_ready) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s6_ready && r_s5_valid) begin
            // six vertices per cell
            r_s6_base.slot <= idx_x4[tqvg_pkg::SLOT_W-1:0] + idx_x2[tqvg_pkg::SLOT_W-1:0];
            r_s6_base.sx0  <= r_s5_sx0;
            r_s6_base.sy0  <= r_s5_sy0;
            r_s6_base.tx0  <= r_s5_tx0;
            r_s6_base.ty0  <= r_s5_ty0;
        end
    end

    // ---------------- vertex sequencer ----------------
    tqvg_pkg::t_vertex      vtx;

    tqvg_vertex_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tile_w  (r_tile_width),
        .i_tile_h  (r_tile_height),
        .i_valid   (r_s6_valid),
        .o_ready   (seq_in_ready),
        .i_base    (r_s6_base),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_vertex  (vtx)
    );

    assign m_axis_tdata = {vtx.ty, vtx.tx, vtx.sy, vtx.sx, vtx.corner, vtx.slot};
    assign m_axis_tlast = vtx.last;

    a_per_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_per_row != '0)
        else $error("tiles per row is zero");

    a_hold_off_after_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (i_cfg_index == tqvg_pkg::REG_ATLAS_WIDTH)) |=> !s_axis_tready)
        else $error("cell taken while tiles per row is rebuilt");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench: map cells in, predicted vertex transfers compared field by field.
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;      // pipeline is eight deep, empty cells leave no trace
    localparam int PHASE_CELLS = 60;
    localparam int RANDOM_PHASES = 6;
    localparam logic [tqvg_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // field positions in the vertex tdata
    localparam int SLOT_LSB   = 0;
    localparam int CORNER_LSB = SLOT_LSB + tqvg_pkg::SLOT_W;
    localparam int SX_LSB     = CORNER_LSB + tqvg_pkg::CORNER_W;
    localparam int SY_LSB     = SX_LSB + tqvg_pkg::SCREEN_W;
    localparam int TX_LSB     = SY_LSB + tqvg_pkg::SCREEN_W;
    localparam int TY_LSB     = TX_LSB + tqvg_pkg::TEXX_W;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [tqvg_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [tqvg_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [tqvg_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;    // cell_column, cell_row, tile_number
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [tqvg_pkg::M_TDATA_W-1:0]   m_axis_tdata;         // slot, corner, sx, sy, tx, ty
    logic                             m_axis_tlast;

    tile_quad_vertex_generator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the register file
    logic [tqvg_pkg::MAPCOL_W-1:0] map_columns_q = tqvg_pkg::MAP_COLUMNS_RST;
    logic [tqvg_pkg::TSIZE_W-1:0]  tile_width_q  = tqvg_pkg::TILE_WIDTH_RST;
    logic [tqvg_pkg::TSIZE_W-1:0]  tile_height_q = tqvg_pkg::TILE_HEIGHT_RST;
    logic [tqvg_pkg::GAP_W-1:0]    tile_gap_q    = tqvg_pkg::TILE_GAP_RST;
    logic [tqvg_pkg::ATLAS_W-1:0]  atlas_width_q = tqvg_pkg::ATLAS_WIDTH_RST;

    tqvg_pkg::t_vertex pending_vertices[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      src_gaps_on = 1'b1;
    bit      sink_stalls_on = 1'b1;

    // six corners of the two triangles covering one cell
    function automatic void predict_tile_vertices(input logic [tqvg_pkg::COL_W-1:0] col,
                                                  input logic [tqvg_pkg::ROW_W-1:0] row,
                                                  input logic [tqvg_pkg::TILE_W-1:0] tile);
        longint unsigned per_row, entry, slot0, sx0, sy0, tx0, ty0, dx, dy;
        tqvg_pkg::t_vertex v;
        int k;
        if (tile == '0)
            return;
        entry = 64'(tile) - 1;
        per_row = 64'(atlas_width_q) / ((tile_width_q == '0) ? 64'd1 : 64'(tile_width_q));
        if (per_row == 0)
            per_row = 1;
        slot0 = (64'(col) + 64'(row) * 64'(map_columns_q)) * tqvg_pkg::VERTS_PER_TILE;
        sx0 = 64'(col) * 64'(tile_width_q);
        sy0 = 64'(row) * 64'(tile_height_q);
        tx0 = (entry % per_row) * (64'(tile_width_q) + 64'(tile_gap_q));
        ty0 = (entry / per_row) * (64'(tile_height_q) + 64'(tile_gap_q));
        for (k = 0; k < tqvg_pkg::VERTS_PER_TILE; k++) begin
            dx = (k == 1 || k == 4 || k == 5) ? 64'(tile_width_q) : 64'd0;
            dy = (k == 2 || k == 3 || k == 5) ? 64'(tile_height_q) : 64'd0;
            v.slot   = tqvg_pkg::SLOT_W'(slot0 + k);
            v.corner = tqvg_pkg::CORNER_W'(k);
            v.sx     = tqvg_pkg::SCREEN_W'(sx0 + dx);
            v.sy     = tqvg_pkg::SCREEN_W'(sy0 + dy);
            v.tx     = tqvg_pkg::TEXX_W'(tx0 + dx);
            v.ty     = tqvg_pkg::TEXY_W'(ty0 + dy);
            v.last   = (tqvg_pkg::CORNER_W'(k) == tqvg_pkg::CORNER_LAST);
            pending_vertices.push_back(v);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: vertex %s mismatch, expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // sink side
    always @(posedge i_clk)
        m_axis_tready <= !sink_stalls_on || ($urandom_range(99) >= 15);

    always @(posedge i_clk) begin
        tqvg_pkg::t_vertex want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_vertices.size() == 0) begin
                $display("%0t: unexpected vertex transfer, expected none got slot %0d",
                         $time, m_axis_tdata[SLOT_LSB +: tqvg_pkg::SLOT_W]);
                mismatch_count++;
            end else begin
                want = pending_vertices.pop_front();
                check_field("vertex_slot", want.slot,
                            m_axis_tdata[SLOT_LSB +: tqvg_pkg::SLOT_W]);
                check_field("corner", want.corner,
                            m_axis_tdata[CORNER_LSB +: tqvg_pkg::CORNER_W]);
                check_field("screen_x", want.sx, m_axis_tdata[SX_LSB +: tqvg_pkg::SCREEN_W]);
                check_field("screen_y", want.sy, m_axis_tdata[SY_LSB +: tqvg_pkg::SCREEN_W]);
                check_field("texel_x", want.tx, m_axis_tdata[TX_LSB +: tqvg_pkg::TEXX_W]);
                check_field("texel_y", want.ty, m_axis_tdata[TY_LSB +: tqvg_pkg::TEXY_W]);
                check_field("last_corner", want.last, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL tile_quad_vertex_generator_unit");
            $finish;
        end
    end

    // Called right after a rising edge; returns right after the edge of the transfer.
    // tvalid stays high so back-to-back cells need no extra assignment.
    task automatic send_cell(input logic [tqvg_pkg::COL_W-1:0] col,
                             input logic [tqvg_pkg::ROW_W-1:0] row,
                             input logic [tqvg_pkg::TILE_W-1:0] tile);
        while (src_gaps_on && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tile, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_tile_vertices(col, row, tile);
    endtask

    // stop sending and let every outstanding vertex come out
    task automatic settle_outputs();
        s_axis_tvalid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tqvg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tqvg_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tqvg_pkg::REG_MAP_COLUMNS: map_columns_q = data[tqvg_pkg::MAPCOL_W-1:0];
            tqvg_pkg::REG_TILE_WIDTH:  tile_width_q  = data[tqvg_pkg::TSIZE_W-1:0];
            tqvg_pkg::REG_TILE_HEIGHT: tile_height_q = data[tqvg_pkg::TSIZE_W-1:0];
            tqvg_pkg::REG_TILE_GAP:    tile_gap_q    = data[tqvg_pkg::GAP_W-1:0];
            tqvg_pkg::REG_ATLAS_WIDTH: atlas_width_q = data[tqvg_pkg::ATLAS_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [tqvg_pkg::CFG_DATA_W-1:0] pick_setting(input int lo, input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return tqvg_pkg::CFG_DATA_W'(lo);
        if (r < 40)
            return tqvg_pkg::CFG_DATA_W'(hi);
        if (r < 50)
            return tqvg_pkg::CFG_DATA_W'($urandom_range(32767, 0));
        return tqvg_pkg::CFG_DATA_W'($urandom_range(hi, lo));
    endfunction

    task automatic test_reset_defaults();
        send_cell(8'd0, 8'd0, 16'd0);
        send_cell(8'd0, 8'd0, 16'd1);
        send_cell(8'd255, 8'd255, 16'd65535);
        send_cell(8'd3, 8'd7, 16'd17);
        send_cell(8'd255, 8'd0, 16'd0);
        send_cell(8'd0, 8'd255, 16'd16);
        settle_outputs();
    endtask

    task automatic test_register_extremes();
        write_reg(tqvg_pkg::REG_MAP_COLUMNS, 15'd256);
        write_reg(tqvg_pkg::REG_TILE_WIDTH, 15'd256);
        write_reg(tqvg_pkg::REG_TILE_HEIGHT, 15'd256);
        write_reg(tqvg_pkg::REG_TILE_GAP, 15'd255);
        write_reg(tqvg_pkg::REG_ATLAS_WIDTH, 15'd16384);
        send_cell(8'd255, 8'd255, 16'd65535);
        send_cell(8'd0, 8'd0, 16'd64);
        send_cell(8'd128, 8'd1, 16'd65);
        settle_outputs();
    endtask

    // tiles per row falls back to a divisor of one, screen x collapses to zero
    task automatic test_zero_tile_width();
        write_reg(tqvg_pkg::REG_TILE_WIDTH, 15'd0);
        write_reg(tqvg_pkg::REG_ATLAS_WIDTH, 15'd100);
        send_cell(8'd200, 8'd9, 16'd1);
        send_cell(8'd5, 8'd5, 16'd150);
        send_cell(8'd255, 8'd255, 16'd65535);
        settle_outputs();
    endtask

    // atlas narrower than one tile: one tile per row
    task automatic test_narrow_atlas();
        write_reg(tqvg_pkg::REG_TILE_WIDTH, 15'd32);
        write_reg(tqvg_pkg::REG_ATLAS_WIDTH, 15'd1);
        send_cell(8'd1, 8'd2, 16'd1);
        send_cell(8'd1, 8'd2, 16'd2);
        send_cell(8'd255, 8'd255, 16'd65535);
        settle_outputs();
    endtask

    // upper data bits dropped, writes to an unmapped index leave everything as is
    task automatic test_register_masking();
        write_reg(tqvg_pkg::REG_MAP_COLUMNS, 15'h7fff);
        write_reg(tqvg_pkg::REG_TILE_WIDTH, 15'h7fff);
        write_reg(tqvg_pkg::REG_TILE_HEIGHT, 15'h7fff);
        write_reg(tqvg_pkg::REG_TILE_GAP, 15'h7fff);
        write_reg(tqvg_pkg::REG_ATLAS_WIDTH, 15'h7fff);
        write_reg(REG_UNMAPPED, 15'h5555);
        send_cell(8'd255, 8'd255, 16'd65535);
        send_cell(8'd17, 8'd200, 16'd1000);
        settle_outputs();
        write_reg(tqvg_pkg::REG_MAP_COLUMNS, 15'd1);
        send_cell(8'd10, 8'd10, 16'd0);
        send_cell(8'd255, 8'd255, 16'd2);
        settle_outputs();
    endtask

    task automatic test_random_phases();
        int phase, n, pick;
        logic [tqvg_pkg::TILE_W-1:0] tile;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            // one phase runs with both sides streaming flat out
            src_gaps_on = (phase != 2);
            sink_stalls_on = (phase != 2);
            write_reg(tqvg_pkg::REG_MAP_COLUMNS, pick_setting(1, 256));
            write_reg(tqvg_pkg::REG_TILE_WIDTH, pick_setting(1, 256));
            write_reg(tqvg_pkg::REG_TILE_HEIGHT, pick_setting(1, 256));
            write_reg(tqvg_pkg::REG_TILE_GAP, pick_setting(0, 255));
            write_reg(tqvg_pkg::REG_ATLAS_WIDTH, pick_setting(1, 16384));
            if ($urandom_range(3) == 0)
                write_reg(REG_UNMAPPED, tqvg_pkg::CFG_DATA_W'($urandom));
            for (n = 0; n < PHASE_CELLS; n++) begin
                if (phase == 3 && n == PHASE_CELLS / 2)
                    settle_outputs();
                pick = $urandom_range(99);
                if (pick < 15)
                    tile = '0;
                else if (pick < 60)
                    tile = tqvg_pkg::TILE_W'($urandom_range(300, 1));
                else if (pick < 65)
                    tile = 16'hffff;
                else
                    tile = tqvg_pkg::TILE_W'($urandom_range(65535, 1));
                send_cell(tqvg_pkg::COL_W'($urandom), tqvg_pkg::ROW_W'($urandom), tile);
            end
            settle_outputs();
        end
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_extremes();
        test_zero_tile_width();
        test_narrow_atlas();
        test_register_masking();
        test_random_phases();
        settle_outputs();
        if (pending_vertices.size() != 0) begin
            $display("%0t: %0d expected vertices never arrived", $time, pending_vertices.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("PASS tile_quad_vertex_generator_unit");
        else
            $display("FAIL tile_quad_vertex_generator_unit");
        $finish;
    end

endmodule

### sim.f
design/tqvg_pkg.sv
design/tqvg_quot_pipe.sv
design/tqvg_vertex_seq.sv
design/tile_quad_vertex_generator_unit.sv
verif/tb_top.sv
